// ===== hw/rtl/rational_gcd_lcm_accumulator_defines.svh =====
// Assertion macros for the rational GCD/LCM accumulator.
// Both expect clk and rst in scope.
`ifndef RATIONAL_GCD_LCM_ACCUMULATOR_DEFINES_SVH
`define RATIONAL_GCD_LCM_ACCUMULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define RGLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgla assertion failed");
// checked on every edge, reset included
`define RGLA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rgla assertion failed");
`else
`define RGLA_ASSERT(lbl, prop)
`define RGLA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/rgla_pkg.sv =====
package rgla_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  typedef logic [VALUE_WIDTH-1:0] val_t;

  // one beat after classification: magnitudes already taken
  typedef struct packed {
    logic kind;
    logic first;
    logic last;
    val_t num;
    val_t den;
  } item_t;

  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    val_t quotient;
    val_t remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EUC,
    S_EUC_DIV,
    S_LCM_Q,
    S_MUL,
    S_RED_N,
    S_RED_D,
    S_END,
    S_EMIT
  } state_t;

  // what the Euclid loop result feeds
  typedef enum logic [2:0] {
    J_GNUM,
    J_LDEN,
    J_LNUM,
    J_GDEN,
    J_RED
  } job_t;

  function automatic val_t magnitude(logic [63:0] raw);
    val_t v;
    v = raw[VALUE_WIDTH-1:0];
    if (v[VALUE_WIDTH-1]) begin
      return val_t'(~v + 1'b1);
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/rgla_front.sv =====
module rgla_front import rgla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [63:0] numerator,
  input  logic [63:0] denominator,
  input  logic        first,
  input  logic        last,
  output logic        item_valid,
  output item_t       item,
  input  logic        pop
);

  item_t            q [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QAW:0]     count;
  logic             push;
  item_t            cls;

  assign in_ready   = (count != (QAW+1)'(QDEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count != '0);
  assign item       = q[rptr];

  always_comb begin
    cls.kind  = kind;
    cls.first = first;
    cls.last  = last;
    cls.num   = magnitude(numerator);
    cls.den   = magnitude(denominator);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/rgla_div.sv =====
module rgla_div import rgla_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  val_t                 rem;
  val_t                 quo;
  val_t                 dvs;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 done;
  logic [VALUE_WIDTH:0] trial;
  logic [VALUE_WIDTH:0] diff;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= CW'(VALUE_WIDTH-1);
    end else if (busy) begin
      if (!diff[VALUE_WIDTH]) begin
        rem <= diff[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== hw/rtl/rgla_back.sv =====
`include "rational_gcd_lcm_accumulator_defines.svh"

module rgla_back import rgla_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  item_t              item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] rnum,
  output logic [62:0]        rden,
  output status_t            status
);

  state_t   state, state_next;
  job_t     job;
  val_t     rn, rd, ind;
  val_t     ea, eb, la, lb;
  val_t     mq, mp, on_n, od;
  logic     mode, ovf, lastf, mov;
  logic [CW-1:0] mcnt;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [VALUE_WIDTH:0] msum;
  logic                 mfinal_ovf;
  val_t                 mres;
  logic                 emit_go;

  rgla_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // shift-add multiply, MSB first; carries out of the top flag overflow
  assign msum = {1'b0, mp[VALUE_WIDTH-2:0], 1'b0} +
                {1'b0, (mq[mcnt] ? lb : val_t'(0))};
  assign mfinal_ovf = mov | mp[VALUE_WIDTH-1] | msum[VALUE_WIDTH];
  assign mres = mfinal_ovf ? '1 : msum[VALUE_WIDTH-1:0];
  assign emit_go = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item.first) begin
            state_next = S_END;
          end else if (!mode) begin
            state_next = S_EUC;
          end else if (rn == '0 || item.num == '0) begin
            state_next = S_END;
          end else begin
            state_next = S_EUC;
          end
        end
      end
      S_EUC: begin
        if (eb != '0) begin
          state_next = S_EUC_DIV;
        end else begin
          unique case (job)
            J_GNUM:         state_next = (rd == '0 || ind == '0) ? S_END : S_EUC;
            J_LDEN, J_LNUM: state_next = S_LCM_Q;
            J_GDEN:         state_next = S_END;
            J_RED:          state_next = S_RED_N;
            default:        state_next = S_END;
          endcase
        end
      end
      S_EUC_DIV: if (drsp.done) state_next = S_EUC;
      S_LCM_Q:   if (drsp.done) state_next = S_MUL;
      S_MUL: begin
        if (mcnt == '0) begin
          state_next = (job == J_LNUM) ? S_EUC : S_END;
        end
      end
      S_RED_N: if (drsp.done) state_next = S_RED_D;
      S_RED_D: if (drsp.done) state_next = S_EMIT;
      S_END: begin
        if (!lastf) begin
          state_next = S_IDLE;
        end else if (rd == '0 || ovf || rn == '0) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_EUC;
        end
      end
      S_EMIT:  if (emit_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = ea;
    dreq.divisor  = eb;
    unique case (state)
      S_IDLE: pop = item_valid;
      S_EUC: begin
        if (eb != '0) begin
          dreq.start = 1'b1;
        end else if (job == J_LDEN || job == J_LNUM) begin
          dreq.start    = 1'b1;
          dreq.dividend = la;
          dreq.divisor  = ea;
        end else if (job == J_RED) begin
          dreq.start    = 1'b1;
          dreq.dividend = rn;
          dreq.divisor  = ea;
        end
      end
      S_RED_N: begin
        dreq.start    = drsp.done;
        dreq.dividend = rd;
        dreq.divisor  = ea;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rn    <= '0;
      rd    <= val_t'(1);
      mode  <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.first) begin
              mode <= item.kind;
              ovf  <= 1'b0;
              rn   <= item.num;
              rd   <= item.den;
            end else if (mode && (rn == '0 || item.num == '0)) begin
              rn <= '0;
              rd <= val_t'(1);
            end
          end
        end
        S_EUC: begin
          if (eb == '0) begin
            if (job == J_GNUM) begin
              rn <= ea;
              if (rd == '0 || ind == '0) begin
                rd <= '0;
              end
            end else if (job == J_GDEN) begin
              rd <= ea;
            end
          end
        end
        S_MUL: begin
          if (mcnt == '0) begin
            if (mfinal_ovf) begin
              ovf <= 1'b1;
            end
            if (job == J_LNUM) begin
              rn <= mres;
            end else begin
              rd <= mres;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ind   <= item.den;
          lastf <= item.last;
          la    <= rn;
          lb    <= item.num;
          ea    <= rn;
          eb    <= item.num;
          job   <= mode ? J_LNUM : J_GNUM;
        end
      end
      S_EUC: begin
        if (eb == '0 && job == J_GNUM) begin
          la  <= rd;
          lb  <= ind;
          ea  <= rd;
          eb  <= ind;
          job <= J_LDEN;
        end
      end
      S_EUC_DIV: begin
        if (drsp.done) begin
          ea <= eb;
          eb <= drsp.remainder;
        end
      end
      S_LCM_Q: begin
        if (drsp.done) begin
          mq   <= drsp.quotient;
          mp   <= '0;
          mov  <= 1'b0;
          mcnt <= CW'(VALUE_WIDTH-1);
        end
      end
      S_MUL: begin
        mp   <= msum[VALUE_WIDTH-1:0];
        mov  <= mfinal_ovf;
        mcnt <= mcnt - 1'b1;
        if (mcnt == '0 && job == J_LNUM) begin
          ea  <= rd;
          eb  <= ind;
          job <= J_GDEN;
        end
      end
      S_END: begin
        ea  <= rn;
        eb  <= rd;
        job <= J_RED;
      end
      S_RED_N: if (drsp.done) on_n <= drsp.quotient;
      S_RED_D: if (drsp.done) od <= drsp.quotient;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_go) begin
      rnum <= '0;
      rden <= 63'(1);
      if (rd == '0) begin
        status <= ST_ZERO_DEN;
      end else if (ovf) begin
        status <= ST_OVERFLOW;
      end else if (rn == '0) begin
        status <= ST_OK;
      end else if (on_n[VALUE_WIDTH-1] || od[VALUE_WIDTH-1]) begin
        status <= ST_OVERFLOW;
      end else begin
        status <= ST_OK;
        rnum   <= 64'(on_n);
        rden   <= 63'(od);
      end
    end
  end

  `RGLA_ASSERT(a_div_start_idle, dreq.start |-> !drsp.busy)
  `RGLA_ASSERT(a_ok_den_nonzero, out_valid && status == ST_OK |-> rden != '0)
  `RGLA_ASSERT(a_err_fields,
    out_valid && status != ST_OK |-> rnum == '0 && rden == 63'(1))
  `RGLA_ASSERT_ALWAYS(a_pop_only_idle, pop |-> state == S_IDLE && item_valid)

endmodule

// ===== hw/rtl/rational_gcd_lcm_accumulator.sv =====
// Rational GCD/LCM list accumulator. Beats carry one signed rational each;
// first opens a list and fixes the mode from kind (0 gcd, 1 lcm), last closes
// it and makes the block return one reduced fraction with a status (0 ok,
// 1 zero denominator, 2 overflow; on an error the fraction reads 0/1).
// Magnitudes are used, the result numerator is never negative and the
// denominator is at least 1. Beats that arrive outside a list keep folding
// into the running fraction in the current mode. A two-beat queue sits in
// front, so input beats are taken while the engine works or a result waits.
// The engine takes one item at a time through a single shared restoring
// divider. Each Euclid step costs one divide, an LCM adds one divide and a
// shift-add multiply, and the final reduction adds its Euclid steps plus
// two divides. A GCD of 64-bit values takes up to about 92 Euclid remainder
// steps, and a first beat without last only loads the running fraction.
module rational_gcd_lcm_accumulator import rgla_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [63:0] numerator,
  input  logic signed [63:0] denominator,
  input  logic               first,
  input  logic               last,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] result_numerator,
  output logic [62:0]        result_denominator,
  output logic [1:0]         status
);

  logic    item_valid;
  item_t   item;
  logic    pop;
  status_t st;

  // front: classify beats (magnitudes) and queue them
  rgla_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .numerator   (numerator),
    .denominator (denominator),
    .first       (first),
    .last        (last),
    .item_valid  (item_valid),
    .item        (item),
    .pop         (pop)
  );

  // back: fold, reduce, hold result
  rgla_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rnum       (result_numerator),
    .rden       (result_denominator),
    .status     (st)
  );

  assign status = st;

endmodule
